[rtl/sorted_array_list_assert.svh]
// ------------------------------------------------------------------------
// Assertion macros for the sorted array list checker
// Clocked on i_clk, disabled while i_rst_n is low.
// ------------------------------------------------------------------------
`ifndef SORTED_ARRAY_LIST_ASSERT_SVH
`define SORTED_ARRAY_LIST_ASSERT_SVH

// same-cycle implication
`define SAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sal_pkg.sv]
// ------------------------------------------------------------------------
// sal_pkg
// Types and constants shared by the sorted array list modules.
// ------------------------------------------------------------------------
package sal_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int IN_KEY_W      = 32;
    localparam int IDX_W         = 4;
    localparam int RKEY_W        = 32;
    localparam int CNT_W         = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [IN_KEY_W-1:0] key;
        logic [IDX_W-1:0]  index;
    } t_item;

    typedef struct packed {
        logic              ok;
        logic [RKEY_W-1:0] read_key;
        logic [CNT_W-1:0]  count;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

[rtl/sal_store.sv]
// ------------------------------------------------------------------------
// sal_store
// Key memory: one write port, one read port with registered data.
// ------------------------------------------------------------------------
module sal_store
    import sal_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [KEY_WIDTH-1:0] o_rdata
);

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

[rtl/sal_cmp.sv]
// ------------------------------------------------------------------------
// sal_cmp
// Shared unsigned key comparator used by the scan.
// ------------------------------------------------------------------------
module sal_cmp
    import sal_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic [KEY_WIDTH-1:0] i_a,
    input  logic [KEY_WIDTH-1:0] i_b,
    output logic                 o_lt,
    output logic                 o_eq
);

    assign o_lt = i_a < i_b;
    assign o_eq = i_a == i_b;

endmodule

[rtl/sal_seq.sv]
// ------------------------------------------------------------------------
// sal_seq
// Command sequencer: indexed read, or a linear scan for the key's position,
// then entries moved one at a time through the memory, read in ST_SH_RD then written in ST_SH_WR.
// ------------------------------------------------------------------------
module sal_seq
    import sal_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    localparam int AW       = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_item                i_item,
    output logic                 o_valid,
    output t_result              o_result,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [KEY_WIDTH-1:0] o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  logic [KEY_WIDTH-1:0] i_rdata,
    output logic [KEY_WIDTH-1:0] o_key,
    input  logic                 i_lt,
    input  logic                 i_eq
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + IDX_W;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_pos, n_pos;
    logic                 r_ok, n_ok;
    logic [RKEY_W-1:0]    r_rkey, n_rkey;

    logic [CW:0]   ptr_p1, ptr_p2, fill_x;
    logic [CW-1:0] ptr_m1;
    logic          idx_ok, full, at_end, found, rm_more_scan, rm_more_sh, ins_last;
    t_state        scan_next;

    assign ptr_p1       = {1'b0, r_ptr} + (CW+1)'(1);
    assign ptr_p2       = ptr_p1 + (CW+1)'(1);
    assign ptr_m1       = r_ptr - CW'(1);
    assign fill_x       = {1'b0, r_fill};
    assign idx_ok       = XW'(i_item.index) < XW'(r_fill);
    assign full         = r_fill == CW'(DEPTH);
    assign at_end       = r_ptr == r_fill;
    assign found        = (r_state == ST_SCAN_CMP) && !i_lt && i_eq;
    assign rm_more_scan = ptr_p1 < fill_x;
    assign rm_more_sh   = ptr_p2 < fill_x;
    assign ins_last     = ptr_m1 == r_pos;

    // where the scan goes once the insert point is known (pos = r_ptr)
    always_comb begin
        case (r_cmd)
            CMD_INSERT: scan_next = at_end ? ST_PUT : ST_SH_RD;
            CMD_REMOVE: scan_next = (found && rm_more_scan) ? ST_SH_RD : ST_DONE;
            default:    scan_next = ST_DONE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_item.cmd)
                        CMD_READ:   n_state = idx_ok ? ST_READ : ST_DONE;
                        CMD_INSERT: n_state = full ? ST_DONE : ST_SCAN_RD;
                        default:    n_state = ST_SCAN_RD;
                    endcase
                end
            end
            ST_SCAN_RD:  n_state = at_end ? scan_next : ST_SCAN_CMP;
            ST_SCAN_CMP: n_state = i_lt ? ST_SCAN_RD : scan_next;
            ST_SH_RD:    n_state = ST_SH_WR;
            ST_SH_WR: begin
                if (r_cmd == CMD_INSERT) begin
                    n_state = ins_last ? ST_PUT : ST_SH_RD;
                end else begin
                    n_state = rm_more_sh ? ST_SH_RD : ST_DONE;
                end
            end
            ST_PUT:  n_state = ST_DONE;
            ST_READ: n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_ok    = r_ok;
        n_rkey  = r_rkey;
        o_we    = 1'b0;
        o_waddr = r_ptr[AW-1:0];
        o_wdata = i_rdata;
        o_raddr = r_ptr[AW-1:0];
        case (r_state)
            ST_IDLE: begin
                o_raddr = AW'(i_item.index);
                if (i_start) begin
                    n_cmd  = i_item.cmd;
                    n_key  = KEY_WIDTH'(i_item.key);
                    n_ptr  = '0;
                    n_ok   = 1'b0;
                    n_rkey = '0;
                end
            end
            ST_SCAN_RD: begin
                if (at_end) begin
                    n_pos = r_ptr;
                end
            end
            ST_SCAN_CMP: begin
                if (i_lt) begin
                    n_ptr = ptr_p1[CW-1:0];
                end else begin
                    n_pos = r_ptr;
                    if (r_cmd == CMD_INSERT) begin
                        n_ptr = r_fill;
                    end
                    if (found && r_cmd == CMD_SEARCH) begin
                        n_ok = 1'b1;
                    end
                    if (found && r_cmd == CMD_REMOVE && !rm_more_scan) begin
                        n_ok   = 1'b1;
                        n_fill = r_fill - CW'(1);
                    end
                end
            end
            ST_SH_RD: begin
                o_raddr = (r_cmd == CMD_INSERT) ? ptr_m1[AW-1:0] : ptr_p1[AW-1:0];
            end
            ST_SH_WR: begin
                o_we = 1'b1;
                if (r_cmd == CMD_INSERT) begin
                    n_ptr = ptr_m1;
                end else begin
                    n_ptr = ptr_p1[CW-1:0];
                    if (!rm_more_sh) begin
                        n_ok   = 1'b1;
                        n_fill = r_fill - CW'(1);
                    end
                end
            end
            ST_PUT: begin
                o_we    = 1'b1;
                o_waddr = r_pos[AW-1:0];
                o_wdata = r_key;
                n_fill  = r_fill + CW'(1);
                n_ok    = 1'b1;
            end
            ST_READ: begin
                n_ok   = 1'b1;
                n_rkey = RKEY_W'(i_rdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_key  <= n_key;
        r_ptr  <= n_ptr;
        r_pos  <= n_pos;
        r_ok   <= n_ok;
        r_rkey <= n_rkey;
    end

    assign o_busy            = r_state != ST_IDLE;
    assign o_valid           = r_state == ST_DONE;
    assign o_result.ok       = r_ok;
    assign o_result.read_key = r_rkey;
    assign o_result.count    = CNT_W'(r_fill);
    assign o_key             = r_key;

endmodule

[rtl/sorted_array_list.sv]
// ------------------------------------------------------------------------
// sorted_array_list
// Sorted key store with insert, remove, search and indexed read.
// ------------------------------------------------------------------------
// A command is taken when start is high and busy is low. One result word
// comes back on o_result for a single cycle with o_valid, and busy drops
// the cycle after. The receiver cannot stall, so the word must be taken in
// that cycle. Keys sit in a single-port-write, registered-read memory that
// one shared comparator scans, one entry at a time. A read fetches the
// entry at its index, or fails if the index is out of range, and an insert
// into a full store is refused. Other commands scan up from the lowest
// entry until one is not below the key. A remove that finds its key moves
// the entries above it down one place; an insert moves the entries from its
// position up one place, then writes the key.
module sorted_array_list
    import sal_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    localparam int AW = $clog2(DEPTH);

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [KEY_WIDTH-1:0] wdata, rdata, key;
    logic                 lt, eq;

    sal_seq #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_key    (key),
        .i_lt     (lt),
        .i_eq     (eq)
    );

    sal_store #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sal_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_a  (rdata),
        .i_b  (key),
        .o_lt (lt),
        .o_eq (eq)
    );

endmodule

[rtl/sal_chk.sv]
// ------------------------------------------------------------------------
// sal_chk
// Port-level checks for the sorted array list, bound to the top level.
// ------------------------------------------------------------------------
`include "sorted_array_list_assert.svh"

module sal_chk
    import sal_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input logic    o_valid,
    input t_result o_result
);

    `SAL_ASSERT_NOW(a_valid_busy, o_valid, busy, "result word outside a command")
    `SAL_ASSERT_NEXT(a_valid_free, o_valid, !busy && !o_valid, "busy held after result")
    `SAL_ASSERT_NEXT(a_take_busy, start && !busy, busy, "command taken but not busy")
    `SAL_ASSERT_NOW(a_fail_zero, o_valid && !o_result.ok, o_result.read_key == '0,
                    "read_key set on failure")

endmodule

bind sorted_array_list sal_chk u_sal_chk (.*);

[verif/sorted_array_list_tb.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// sorted_array_list_tb
// Self-checking bench for the sorted key store. A local model of the list
// predicts every result word; directed cases cover empty, duplicate, full
// and single-entry corners, then weighted random traffic walks the fill
// level between empty and full with random sender gaps.
// ------------------------------------------------------------------------
module sorted_array_list_tb;
    import sal_pkg::*;

    localparam int          LIST_DEPTH  = DEPTH_DEF;
    localparam int          TAIL_CYCLES = 120;
    localparam int unsigned STALL_LIMIT = 2000;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_valid;
    t_result o_result;

    // local copy of the list
    logic [31:0] list_keys [LIST_DEPTH];
    int unsigned list_fill;

    t_result     pending_results[$];
    t_result     want_word;
    bit          gaps_on;
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned full_rejects;
    int unsigned full_hits;
    int unsigned bad_reads;
    int unsigned lookup_hits;
    int unsigned stall_cycles = 0;

    sorted_array_list i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one command to the local list and return the result word
    function automatic t_result apply_cmd(t_item it);
        t_result     r;
        int unsigned pos;
        r   = '0;
        pos = 0;
        while (pos < list_fill && list_keys[pos] < it.key)
            pos++;
        case (it.cmd)
            CMD_INSERT: begin
                if (list_fill < LIST_DEPTH) begin
                    for (int j = list_fill; j > pos; j--)
                        list_keys[j] = list_keys[j-1];
                    list_keys[pos] = it.key;
                    list_fill++;
                    r.ok = 1'b1;
                    if (list_fill == LIST_DEPTH)
                        full_hits++;
                end else begin
                    full_rejects++;
                end
            end
            CMD_REMOVE: begin
                if (pos < list_fill && list_keys[pos] == it.key) begin
                    for (int j = pos; j + 1 < list_fill; j++)
                        list_keys[j] = list_keys[j+1];
                    list_fill--;
                    r.ok = 1'b1;
                    lookup_hits++;
                end
            end
            CMD_SEARCH: begin
                r.ok = (pos < list_fill && list_keys[pos] == it.key);
                if (r.ok)
                    lookup_hits++;
            end
            default: begin
                if (it.index < list_fill) begin
                    r.ok       = 1'b1;
                    r.read_key = list_keys[it.index];
                end else begin
                    bad_reads++;
                end
            end
        endcase
        r.count = list_fill[CNT_W-1:0];
        return r;
    endfunction

    // mostly small or already stored keys so lookups hit; some full-range
    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 7);
        if (r < 7 && list_fill > 0)
            return list_keys[$urandom_range(0, list_fill - 1)];
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic t_item rand_item(int unsigned w_ins, int unsigned w_rem,
                                        int unsigned w_srch, int unsigned w_rd);
        t_item       it;
        int unsigned r;
        r        = $urandom_range(0, w_ins + w_rem + w_srch + w_rd - 1);
        it.key   = pick_key();
        if ($urandom_range(0, 3) == 0 || list_fill == 0)
            it.index = IDX_W'($urandom_range(0, 15));
        else
            it.index = IDX_W'($urandom_range(0, list_fill - 1));
        if (r < w_ins)
            it.cmd = CMD_INSERT;
        else if (r < w_ins + w_rem)
            it.cmd = CMD_REMOVE;
        else if (r < w_ins + w_rem + w_srch)
            it.cmd = CMD_SEARCH;
        else
            it.cmd = CMD_READ;
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // returns at the edge where the word is taken; start is left high so a
    // back-to-back word does not drop it
    task automatic send_word(input t_item it);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_cmd(it));
        words_sent++;
    endtask

    task automatic send_cmd(input t_cmd c, input logic [31:0] key,
                            input logic [IDX_W-1:0] idx);
        t_item it;
        it.cmd   = c;
        it.key   = key;
        it.index = idx;
        send_word(it);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_corners();
        gaps_on = 1'b0;
        // empty store
        send_cmd(CMD_SEARCH, 32'h0, 4'd0);
        send_cmd(CMD_REMOVE, 32'h0, 4'd0);
        send_cmd(CMD_READ,   32'h0, 4'd0);
        send_cmd(CMD_READ,   32'hFFFF_FFFF, 4'd15);
        // extremes and a duplicate pair
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_cmd(CMD_INSERT, 32'h0000_0000, 4'd0);
        send_cmd(CMD_INSERT, 32'h8000_0000, 4'd0);
        send_cmd(CMD_INSERT, 32'h0000_0005, 4'd0);
        send_cmd(CMD_INSERT, 32'h0000_0005, 4'd0);
        send_cmd(CMD_READ,   32'h0, 4'd2);
        send_cmd(CMD_READ,   32'h0, 4'd4);
        send_cmd(CMD_READ,   32'h0, 4'd5);
        send_cmd(CMD_SEARCH, 32'h0000_0005, 4'd0);
        send_cmd(CMD_SEARCH, 32'h0000_0006, 4'd0);
        send_cmd(CMD_REMOVE, 32'h0000_0006, 4'd0);
        send_cmd(CMD_REMOVE, 32'h0000_0005, 4'd0);
        send_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);
        send_cmd(CMD_REMOVE, 32'h0000_0000, 4'd0);
        send_cmd(CMD_REMOVE, 32'h0000_0005, 4'd0);
        // last entry leaves
        send_cmd(CMD_REMOVE, 32'h8000_0000, 4'd0);
        send_cmd(CMD_READ,   32'h0, 4'd0);
    endtask

    task automatic test_full_store();
        gaps_on = 1'b1;
        while (list_fill < LIST_DEPTH)
            send_cmd(CMD_INSERT, pick_key(), 4'd0);
        send_cmd(CMD_INSERT, 32'h0000_0000, 4'd0);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        send_cmd(CMD_READ,   32'h0, 4'd15);
        send_cmd(CMD_READ,   32'h0, 4'd0);
        send_cmd(CMD_SEARCH, list_keys[LIST_DEPTH-1], 4'd0);
        while (list_fill > 0)
            send_cmd(CMD_REMOVE, list_keys[$urandom_range(0, list_fill - 1)], 4'd0);
        send_cmd(CMD_REMOVE, 32'h0, 4'd0);
        send_cmd(CMD_SEARCH, 32'h0, 4'd0);
    endtask

    // phases bias the mix so the fill level swings between empty and full
    task automatic test_random_mix(input int unsigned n_words);
        int unsigned phase;
        phase = 0;
        for (int k = 0; k < n_words; k++) begin
            if (k % 120 == 0) begin
                phase   = $urandom_range(0, 3);
                gaps_on = $urandom_range(0, 1);
            end
            case (phase)
                0:       send_word(rand_item(6, 1, 2, 2));
                1:       send_word(rand_item(1, 6, 2, 2));
                2:       send_word(rand_item(3, 3, 2, 2));
                default: send_word(rand_item(2, 2, 4, 4));
            endcase
        end
    endtask

    // sender holds off until the block has answered everything
    task automatic test_pause_drain();
        gaps_on = 1'b1;
        for (int b = 0; b < 5; b++) begin
            for (int k = 0; k < 10; k++)
                send_word(rand_item(3, 2, 2, 2));
            wait_all_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with none pending: %p", o_result));
            end else begin
                want_word = pending_results.pop_front();
                if (o_result.ok !== want_word.ok)
                    report_mismatch($sformatf("ok got %b want %b",
                                              o_result.ok, want_word.ok));
                if (o_result.read_key !== want_word.read_key)
                    report_mismatch($sformatf("read_key got %h want %h",
                                              o_result.read_key, want_word.read_key));
                if (o_result.count !== want_word.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              o_result.count, want_word.count));
            end
        end
    end

    // watchdog: cycles with no command word taken
    always @(posedge i_clk) begin
        if (start && !busy)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        list_fill       = 0;
        gaps_on         = 1'b0;
        error_count     = 0;
        words_sent      = 0;
        results_checked = 0;
        full_rejects    = 0;
        full_hits       = 0;
        bad_reads       = 0;
        lookup_hits     = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corners();
        test_full_store();
        test_random_mix(700);
        test_pause_drain();
        test_random_mix(740);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d words sent, %0d results checked; store filled %0d times,",
                 words_sent, results_checked, full_hits);
        $display("%0d inserts refused when full, %0d out-of-range reads, %0d lookup hits",
                 full_rejects, bad_reads, lookup_hits);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/sal_pkg.sv
rtl/sal_store.sv
rtl/sal_cmp.sv
rtl/sal_seq.sv
rtl/sorted_array_list.sv
rtl/sal_chk.sv
verif/sorted_array_list_tb.sv
